// ----- src/pcrr_pkg.sv -----
`default_nettype none
package pcrr_pkg;

  localparam int unsigned FRAME_WORDS = 4;
  localparam int unsigned FW_IDX_W    = $clog2(FRAME_WORDS);
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // raw op codes on the input channel
  localparam logic [OP_W-1:0] OP_EDGE = 2'd0;
  localparam logic [OP_W-1:0] OP_GAP  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  typedef enum logic [1:0] {
    EV_EDGE = 2'd0,
    EV_GAP  = 2'd1,
    EV_TICK = 2'd2,
    EV_NONE = 2'd3
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e kind;
    logic     pressed;
  } item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOST_LIMIT      = 2'd0,
    CFG_PAIRING_TIMEOUT = 2'd1,
    CFG_HOLD_TICKS      = 2'd2,
    CFG_LEAD_PULSES     = 2'd3
  } cfg_reg_e;

  localparam logic [7:0] RST_LOST_LIMIT      = 8'd50;
  localparam logic [7:0] RST_PAIRING_TIMEOUT = 8'd250;
  localparam logic [4:0] RST_HOLD_TICKS      = 5'd16;
  localparam logic [3:0] RST_LEAD_PULSES     = 4'd4;
  localparam logic [7:0] RST_ADDRESS         = 8'd10;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_PAIRING = 3'd5;

  localparam logic [7:0] SYNC_MARK    = 8'h55;
  localparam logic [7:0] TRAILER      = 8'hAA;
  localparam logic [7:0] ADDR_BLINK_BASE = 8'd9;
  localparam logic [4:0] PAIR_LEAD_STEPS = 5'd3;
  localparam logic [4:0] BLINK_PAT_STEPS = 5'd8;
  localparam logic [4:0] BLINK_LAST      = 5'd16;

  // indicator pattern per mode, shifted out lsb first
  function automatic logic [7:0] blink_pattern(input logic [2:0] mode);
    logic [7:0] pat;
    case (mode)
      3'd0:    pat = 8'b1111_0000;
      3'd1:    pat = 8'b1000_0000;
      3'd2:    pat = 8'b1010_0000;
      3'd3:    pat = 8'b1010_1000;
      3'd4:    pat = 8'b1010_1010;
      default: pat = 8'b0000_0000;
    endcase
    return pat;
  endfunction

  function automatic logic [3:0] zone_onehot(input logic [2:0] mode);
    logic [3:0] z;
    case (mode)
      3'd1:    z = 4'b0001;
      3'd2:    z = 4'b0010;
      3'd3:    z = 4'b0100;
      3'd4:    z = 4'b1000;
      default: z = 4'b0000;
    endcase
    return z;
  endfunction

endpackage
`default_nettype wire

// ----- src/pcrr_front.sv -----
`default_nettype none
module pcrr_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [pcrr_pkg::OP_W-1:0]   op_i,
  input  wire logic                        button_pressed_i,
  output logic                             push_valid_o,
  input  wire logic                        push_ready_i,
  output pcrr_pkg::item_t                  push_item_o
);

  logic            valid_q;
  pcrr_pkg::item_t item_q, item_d;

  assign in_ready_o   = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

  always_comb begin
    item_d.pressed = button_pressed_i;
    case (op_i)
      pcrr_pkg::OP_EDGE: item_d.kind = pcrr_pkg::EV_EDGE;
      pcrr_pkg::OP_GAP:  item_d.kind = pcrr_pkg::EV_GAP;
      pcrr_pkg::OP_TICK: item_d.kind = pcrr_pkg::EV_TICK;
      default:           item_d.kind = pcrr_pkg::EV_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/pcrr_queue.sv -----
`default_nettype none
module pcrr_queue #(
  parameter int unsigned Depth = pcrr_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire pcrr_pkg::item_t push_item_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output pcrr_pkg::item_t      pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  pcrr_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntFull);
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ----- src/pcrr_back.sv -----
`default_nettype none
module pcrr_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic [pcrr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [pcrr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              pop_valid_i,
  output logic                                   pop_ready_o,
  input  wire pcrr_pkg::item_t                   pop_item_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [2:0]                             mode_o,
  output logic [3:0]                             zone_drive_o,
  output logic                                   led_on_o,
  output logic                                   link_lost_o,
  output logic [7:0]                             paired_address_o,
  output logic                                   frame_accepted_o
);

  localparam int unsigned IdxW = pcrr_pkg::FW_IDX_W;

  // configuration registers
  logic [7:0] lost_limit_q, pair_timeout_q;
  logic [4:0] hold_ticks_q;
  logic [3:0] lead_pulses_q;

  // receiver state
  logic [2:0]      mode_q, mode_d;
  logic [7:0]      learned_q, learned_d;
  logic [7:0]      edge_q, edge_d;
  logic            pending_q, pending_d;
  logic [IdxW-1:0] widx_q, widx_d;
  logic [7:0]      lost_q, lost_d;
  logic [4:0]      hold_q, hold_d;
  logic [7:0]      pair_q, pair_d;
  logic [4:0]      blink_q, blink_d;
  logic            led_q, led_d;
  logic [7:0]      words_q [pcrr_pkg::FRAME_WORDS];

  logic            out_valid_q;
  logic            fire;
  logic            accepted;
  logic [7:0]      word;
  logic            restart;
  logic [IdxW-1:0] wr_idx;
  logic [7:0]      head;
  logic            frame_ok;
  logic            word_we;
  logic [4:0]      pair_step;
  logic [7:0]      addr_digits;
  logic [7:0]      blink_pat;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign fire        = pop_valid_i && pop_ready_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_limit_q   <= pcrr_pkg::RST_LOST_LIMIT;
      pair_timeout_q <= pcrr_pkg::RST_PAIRING_TIMEOUT;
      hold_ticks_q   <= pcrr_pkg::RST_HOLD_TICKS;
      lead_pulses_q  <= pcrr_pkg::RST_LEAD_PULSES;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pcrr_pkg::CFG_LOST_LIMIT:      lost_limit_q   <= cfg_data_i;
        pcrr_pkg::CFG_PAIRING_TIMEOUT: pair_timeout_q <= cfg_data_i;
        pcrr_pkg::CFG_HOLD_TICKS:      hold_ticks_q   <= cfg_data_i[4:0];
        pcrr_pkg::CFG_LEAD_PULSES:     lead_pulses_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // word assembly and frame check
  assign word     = edge_q - {4'b0000, lead_pulses_q};
  assign restart  = (word == learned_q) || (word == pcrr_pkg::SYNC_MARK);
  assign wr_idx   = restart ? '0 : widx_q;
  assign head     = (mode_q == pcrr_pkg::MODE_PAIRING) ? pcrr_pkg::SYNC_MARK : learned_q;
  assign frame_ok = (wr_idx == IdxW'(pcrr_pkg::FRAME_WORDS - 1)) && (words_q[0] == head)
                 && (words_q[1] == words_q[2]) && (word == pcrr_pkg::TRAILER);
  assign word_we  = (pop_item_i.kind == pcrr_pkg::EV_GAP) && pending_q;

  always_comb begin
    mode_d      = mode_q;
    learned_d   = learned_q;
    edge_d      = edge_q;
    pending_d   = pending_q;
    widx_d      = widx_q;
    lost_d      = lost_q;
    hold_d      = pop_item_i.pressed ? hold_q : 5'd0;
    pair_d      = pair_q;
    blink_d     = blink_q;
    led_d       = led_q;
    accepted    = 1'b0;
    pair_step   = '0;
    addr_digits = '0;
    blink_pat   = '0;
    case (pop_item_i.kind)
      pcrr_pkg::EV_EDGE: begin
        edge_d    = edge_q + 8'd1;
        pending_d = 1'b1;
      end
      pcrr_pkg::EV_GAP: begin
        if (pending_q) begin
          widx_d    = wr_idx + IdxW'(1);
          edge_d    = '0;
          pending_d = 1'b0;
          if (frame_ok) begin
            accepted = 1'b1;
            lost_d   = '0;
            if (mode_q == pcrr_pkg::MODE_PAIRING) begin
              if (learned_q != words_q[1]) begin
                learned_d = words_q[1];
                blink_d   = '0;
                pair_d    = '0;
              end
            end else if (words_q[1] <= {5'b00000, pcrr_pkg::MODE_PAIRING}) begin
              mode_d = words_q[1][2:0];
            end
          end
          if (mode_d != mode_q) begin
            blink_d = '0;
          end
        end
      end
      pcrr_pkg::EV_TICK: begin
        // indicator sequencer
        if (mode_d == pcrr_pkg::MODE_PAIRING) begin
          pair_step   = blink_d - pcrr_pkg::PAIR_LEAD_STEPS;
          addr_digits = learned_d - pcrr_pkg::ADDR_BLINK_BASE;
          if (blink_d < pcrr_pkg::PAIR_LEAD_STEPS) begin
            led_d = 1'b1;
          end else if (blink_d[0]) begin
            led_d = 1'b0;
          end else begin
            // one blink per address unit above the base
            led_d = (learned_d >= pcrr_pkg::ADDR_BLINK_BASE)
                 && ({4'b0000, pair_step[4:1]} < addr_digits);
          end
        end else if (lost_d > lost_limit_q) begin
          led_d = !led_d;
          if (mode_d != pcrr_pkg::MODE_IDLE) begin
            mode_d  = pcrr_pkg::MODE_IDLE;
            blink_d = '0;
          end
        end else if (blink_d < pcrr_pkg::BLINK_PAT_STEPS) begin
          blink_pat = pcrr_pkg::blink_pattern(mode_d);
          led_d     = blink_pat[blink_d[2:0]];
        end else begin
          led_d = 1'b0;
        end
        blink_d = blink_d + 5'd1;
        if (blink_d > pcrr_pkg::BLINK_LAST) begin
          blink_d = '0;
        end
        // lost-link timer
        if (lost_d <= lost_limit_q && lost_d != 8'hFF) begin
          lost_d = lost_d + 8'd1;
        end
        // long press enters pairing at once
        if (hold_d > hold_ticks_q) begin
          led_d   = 1'b1;
          mode_d  = pcrr_pkg::MODE_PAIRING;
          hold_d  = '0;
          pair_d  = '0;
          blink_d = '0;
        end else if (pop_item_i.pressed && hold_d <= hold_ticks_q && hold_d != 5'h1F) begin
          hold_d = hold_d + 5'd1;
        end
        if (mode_d == pcrr_pkg::MODE_PAIRING) begin
          if (pair_d != 8'hFF) begin
            pair_d = pair_d + 8'd1;
          end
          if (pair_d > pair_timeout_q) begin
            pair_d = '0;
            mode_d = pcrr_pkg::MODE_IDLE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= pcrr_pkg::MODE_IDLE;
      learned_q   <= pcrr_pkg::RST_ADDRESS;
      edge_q      <= '0;
      pending_q   <= 1'b0;
      widx_q      <= '0;
      lost_q      <= '0;
      hold_q      <= '0;
      pair_q      <= '0;
      blink_q     <= '0;
      led_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        mode_q    <= mode_d;
        learned_q <= learned_d;
        edge_q    <= edge_d;
        pending_q <= pending_d;
        widx_q    <= widx_d;
        lost_q    <= lost_d;
        hold_q    <= hold_d;
        pair_q    <= pair_d;
        blink_q   <= blink_d;
        led_q     <= led_d;
      end
      if (pop_ready_o) begin
        out_valid_q <= pop_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && word_we) begin
      words_q[wr_idx] <= word;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      mode_o           <= mode_d;
      zone_drive_o     <= pcrr_pkg::zone_onehot(mode_d);
      led_on_o         <= led_d;
      link_lost_o      <= (lost_d > lost_limit_q);
      paired_address_o <= learned_d;
      frame_accepted_o <= accepted;
    end
  end

endmodule
`default_nettype wire

// ----- src/pulse_count_relay_receiver.sv -----
// path: an input transaction passes the front register and then the event queue, and the
// state update in the back end then loads the result register
// throughput: one event per cycle while out_ready_i does not stall the output, set by the state update in the back end
// reset: rst_ni low clears all control state and loads the register defaults
// and the default address; no clearing pass, events are taken right after reset
`default_nettype none
module pulse_count_relay_receiver #(
  parameter int unsigned QueueDepth = pcrr_pkg::QUEUE_DEPTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [pcrr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [pcrr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [pcrr_pkg::OP_W-1:0]         op_i,
  input  wire logic                              button_pressed_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [2:0]                             mode_o,
  output logic [3:0]                             zone_drive_o,
  output logic                                   led_on_o,
  output logic                                   link_lost_o,
  output logic [7:0]                             paired_address_o,
  output logic                                   frame_accepted_o
);

  logic            push_valid, push_ready;
  pcrr_pkg::item_t push_item;
  logic            pop_valid, pop_ready;
  pcrr_pkg::item_t pop_item;

  assign cfg_ready_o = 1'b1;

  pcrr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .button_pressed_i (button_pressed_i),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_item_o      (push_item)
  );

  pcrr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  pcrr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_item_i       (pop_item),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .mode_o           (mode_o),
    .zone_drive_o     (zone_drive_o),
    .led_on_o         (led_on_o),
    .link_lost_o      (link_lost_o),
    .paired_address_o (paired_address_o),
    .frame_accepted_o (frame_accepted_o)
  );

endmodule
`default_nettype wire
